### rtl/mcb_pkg.sv
package mcb_pkg;

    // Coordinate arithmetic width: holds a 6-bit position plus or minus two and any grid side.
    localparam int CW = 10;

    typedef enum logic [2:0] {
        ST_CARVED   = 3'd0,
        ST_SKIPPED  = 3'd1,
        ST_BACK     = 3'd2,
        ST_FINISHED = 3'd3,
        ST_STARTED  = 3'd4,
        ST_TILE     = 3'd5,
        ST_BADDIM   = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        FN_START = 2'd0,
        FN_STEP  = 2'd1,
        FN_READ  = 2'd2,
        FN_NONE  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        DIR_UP    = 2'd0,
        DIR_DOWN  = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } t_dir;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_QREAD,
        S_DECODE,
        S_CHECK,
        S_CARVE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [2:0] tried;
        logic [4:0] perm;
        logic [5:0] y;
        logic [5:0] x;
    } t_entry;

    typedef struct packed {
        t_status    status;
        logic [5:0] cell_x;
        logic [5:0] cell_y;
        logic [5:0] wall_x;
        logic [5:0] wall_y;
        logic       tile_open;
    } t_result;

    localparam int APB_ADDR_W = 3;
    localparam logic [APB_ADDR_W-1:0] REG_WIDTH  = 3'h0;
    localparam logic [APB_ADDR_W-1:0] REG_HEIGHT = 3'h4;

    // Lexicographic permutations of the four directions; position p sits in bits [2p+1:2p].
    localparam logic [7:0] PERM_TAB [24] = '{
        8'hE4, 8'hB4, 8'hD8, 8'h78, 8'h9C, 8'h6C,
        8'hE1, 8'hB1, 8'hC9, 8'h39, 8'h8D, 8'h2D,
        8'hD2, 8'h72, 8'hC6, 8'h36, 8'h4E, 8'h1E,
        8'h93, 8'h63, 8'h87, 8'h27, 8'h4B, 8'h1B
    };

    function automatic t_dir perm_dir(input logic [4:0] perm, input logic [1:0] pos);
        logic [7:0] row;
        row = PERM_TAB[perm];
        return t_dir'(row[2*pos +: 2]);
    endfunction

endpackage

### rtl/maze_carver_backtracker.sv
// Maze carver: a randomised depth-first backtracker over a tile grid of up to MAX_SIDE by
// MAX_SIDE tiles, with its explicit cell stack of STACK_DEPTH entries. Each item gives exactly
// one result, except an item with the unused function code, which gives none. The grid and the
// stack each live in a single-port-style synchronous memory with a registered read port, and
// every item is handled by read, decide and write-back steps of a small sequencer, one item at a
// time. A carving step that carves reads the stack, reads the grid, writes the wall, writes the
// cell and hands off the result, in that order; one that skips leaves out the two writes, and one
// that backtracks also leaves out the grid read. A tile read reads the grid and hands off the
// result, and a finished or bad-dimension answer goes straight to the hand-off. A start item sweeps
// the whole grid one tile per cycle; the same sweep runs after reset, during which no item is
// accepted although register writes are still taken. Results wait in an output register, so a
// new item may be accepted while the previous result is still stalled.
module maze_carver_backtracker #(
    parameter int MAX_SIDE    = 64,
    parameter int STACK_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [4:0]  i_perm_choice,
    input  logic [5:0]  i_query_x,
    input  logic [5:0]  i_query_y,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [5:0]  o_cell_x,
    output logic [5:0]  o_cell_y,
    output logic [5:0]  o_wall_x,
    output logic [5:0]  o_wall_y,
    output logic        o_tile_open,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [mcb_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int GN  = MAX_SIDE * MAX_SIDE;
    localparam int GAW = $clog2(GN);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int DW  = $clog2(STACK_DEPTH + 1);
    localparam int CW  = mcb_pkg::CW;

    localparam logic [GAW-1:0] CLR_LAST  = GAW'(GN - 1);
    localparam logic [GAW-1:0] START_IDX = GAW'(MAX_SIDE + 1);

    // Memories.
    logic grid_mem [GN];
    mcb_pkg::t_entry stk_mem [STACK_DEPTH];

    logic           g_we, g_wd, g_re;
    logic [GAW-1:0] g_wa, g_ra;
    logic           r_g_q;
    logic           s_we, s_re;
    logic [SAW-1:0] s_wa, s_ra;
    mcb_pkg::t_entry s_wd, r_s_q;

    // Control and datapath registers.
    mcb_pkg::t_state  r_state, n_state;
    logic [GAW-1:0]   r_clr, n_clr;
    logic             r_clr_rep, n_clr_rep;
    logic [4:0]       r_perm, n_perm;
    logic [DW-1:0]    r_depth, n_depth;
    logic [5:0]       r_width, r_height;
    logic signed [CW-1:0] r_nx, n_nx, r_ny, n_ny;
    logic [5:0]       r_wx, n_wx, r_wy, n_wy;
    logic             r_inb, n_inb;
    mcb_pkg::t_result r_res, n_res;
    logic             r_ov, n_ov;
    mcb_pkg::t_result r_out, n_out;

    logic accept, out_free, cfg_wr, dims_good;
    logic [SAW-1:0] top;
    mcb_pkg::t_dir dir;
    logic signed [CW-1:0] cx, cy, tx, ty;
    logic [5:0] wx_c, wy_c;
    logic q_inr, t_inb;
    logic [4:0] perm_in;

    function automatic logic dim_ok(input logic [5:0] v);
        return (v >= 6'd5) && v[0] && (int'(v) <= MAX_SIDE);
    endfunction

    always_comb begin
        accept    = i_in_valid && !o_in_stall;
        out_free  = !r_ov || !i_out_stall;
        cfg_wr    = psel && penable && pwrite && pready;
        dims_good = dim_ok(r_width) && dim_ok(r_height);
        top       = SAW'(r_depth - DW'(1));
        perm_in   = (i_perm_choice >= 5'd24) ? i_perm_choice - 5'd24 : i_perm_choice;
        q_inr     = (int'(i_query_x) < MAX_SIDE) && (int'(i_query_y) < MAX_SIDE);
    end

    // Direction and target of the top cell (valid in S_DECODE).
    always_comb begin
        dir  = mcb_pkg::perm_dir(r_s_q.perm, r_s_q.tried[1:0]);
        cx   = CW'(r_s_q.x);
        cy   = CW'(r_s_q.y);
        tx   = cx;
        ty   = cy;
        wx_c = r_s_q.x;
        wy_c = r_s_q.y;
        case (dir)
            mcb_pkg::DIR_UP: begin
                ty   = cy - CW'(2);
                wy_c = r_s_q.y - 6'd1;
            end
            mcb_pkg::DIR_DOWN: begin
                ty   = cy + CW'(2);
                wy_c = r_s_q.y + 6'd1;
            end
            mcb_pkg::DIR_LEFT: begin
                tx   = cx - CW'(2);
                wx_c = r_s_q.x - 6'd1;
            end
            default: begin
                tx   = cx + CW'(2);
                wx_c = r_s_q.x + 6'd1;
            end
        endcase
        // Strictly inside the border of the current dimensions and inside storage.
        t_inb = (tx > 0) && (ty > 0)
             && (tx < $signed(CW'(r_width)) - CW'(1))
             && (ty < $signed(CW'(r_height)) - CW'(1))
             && (tx < CW'(MAX_SIDE)) && (ty < CW'(MAX_SIDE));
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            mcb_pkg::S_CLEAR: begin
                if (r_clr == CLR_LAST) begin
                    n_state = r_clr_rep ? mcb_pkg::S_EMIT : mcb_pkg::S_IDLE;
                end
            end
            mcb_pkg::S_IDLE: begin
                if (accept) begin
                    case (mcb_pkg::t_func'(i_func))
                        mcb_pkg::FN_START: begin
                            n_state = dims_good ? mcb_pkg::S_CLEAR : mcb_pkg::S_EMIT;
                        end
                        mcb_pkg::FN_STEP: begin
                            n_state = (r_depth == '0) ? mcb_pkg::S_EMIT : mcb_pkg::S_DECODE;
                        end
                        mcb_pkg::FN_READ: n_state = mcb_pkg::S_QREAD;
                        default:          n_state = mcb_pkg::S_IDLE;
                    endcase
                end
            end
            mcb_pkg::S_QREAD:  n_state = mcb_pkg::S_EMIT;
            mcb_pkg::S_DECODE: begin
                n_state = (r_s_q.tried >= 3'd4) ? mcb_pkg::S_EMIT : mcb_pkg::S_CHECK;
            end
            mcb_pkg::S_CHECK: begin
                n_state = (!r_inb || r_g_q || (int'(r_depth) >= STACK_DEPTH))
                        ? mcb_pkg::S_EMIT : mcb_pkg::S_CARVE;
            end
            mcb_pkg::S_CARVE: n_state = mcb_pkg::S_EMIT;
            mcb_pkg::S_EMIT: begin
                if (out_free) begin
                    n_state = mcb_pkg::S_IDLE;
                end
            end
            default: n_state = mcb_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        o_in_stall = (r_state != mcb_pkg::S_IDLE);
        g_we = 1'b0; g_wa = '0; g_wd = 1'b0; g_re = 1'b0; g_ra = '0;
        s_we = 1'b0; s_wa = '0; s_wd = '0;   s_re = 1'b0; s_ra = '0;
        n_clr = r_clr; n_clr_rep = r_clr_rep; n_perm = r_perm; n_depth = r_depth;
        n_nx = r_nx; n_ny = r_ny; n_wx = r_wx; n_wy = r_wy; n_inb = r_inb;
        n_res = r_res; n_ov = r_ov; n_out = r_out;
        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end
        case (r_state)
            mcb_pkg::S_CLEAR: begin
                g_we  = 1'b1;
                g_wa  = r_clr;
                g_wd  = r_clr_rep && (r_clr == START_IDX);
                n_clr = r_clr + GAW'(1);
                n_res = '0;
                n_res.status = mcb_pkg::ST_STARTED;
            end
            mcb_pkg::S_IDLE: begin
                if (accept) begin
                    n_perm = perm_in;
                    n_res  = '0;
                    case (mcb_pkg::t_func'(i_func))
                        mcb_pkg::FN_START: begin
                            if (dims_good) begin
                                n_clr     = '0;
                                n_clr_rep = 1'b1;
                                n_depth   = DW'(1);
                                s_we      = 1'b1;
                                s_wa      = '0;
                                s_wd      = '{tried: 3'd0, perm: perm_in, y: 6'd1, x: 6'd1};
                            end else begin
                                n_depth      = '0;
                                n_res.status = mcb_pkg::ST_BADDIM;
                            end
                        end
                        mcb_pkg::FN_STEP: begin
                            n_res.status = mcb_pkg::ST_FINISHED;
                            s_re = 1'b1;
                            s_ra = top;
                        end
                        mcb_pkg::FN_READ: begin
                            n_inb = q_inr;
                            g_re  = 1'b1;
                            g_ra  = GAW'(i_query_y) * GAW'(MAX_SIDE) + GAW'(i_query_x);
                        end
                        default: ;
                    endcase
                end
            end
            mcb_pkg::S_QREAD: begin
                n_res.status    = mcb_pkg::ST_TILE;
                n_res.tile_open = r_inb && r_g_q;
            end
            mcb_pkg::S_DECODE: begin
                if (r_s_q.tried >= 3'd4) begin
                    n_depth      = r_depth - DW'(1);
                    n_res.status = mcb_pkg::ST_BACK;
                end else begin
                    s_we  = 1'b1;
                    s_wa  = top;
                    s_wd  = r_s_q;
                    s_wd.tried = r_s_q.tried + 3'd1;
                    n_nx  = tx;
                    n_ny  = ty;
                    n_wx  = wx_c;
                    n_wy  = wy_c;
                    n_inb = t_inb;
                    g_re  = t_inb;
                    g_ra  = GAW'(ty) * GAW'(MAX_SIDE) + GAW'(tx);
                    n_res.status = mcb_pkg::ST_SKIPPED;
                end
            end
            mcb_pkg::S_CHECK: begin
                g_we = 1'b1 && r_inb && !r_g_q && (int'(r_depth) < STACK_DEPTH);
                g_wa = GAW'(r_wy) * GAW'(MAX_SIDE) + GAW'(r_wx);
                g_wd = 1'b1;
            end
            mcb_pkg::S_CARVE: begin
                g_we    = 1'b1;
                g_wa    = GAW'(r_ny) * GAW'(MAX_SIDE) + GAW'(r_nx);
                g_wd    = 1'b1;
                s_we    = 1'b1;
                s_wa    = SAW'(r_depth);
                s_wd    = '{tried: 3'd0, perm: r_perm, y: r_ny[5:0], x: r_nx[5:0]};
                n_depth = r_depth + DW'(1);
                n_res.status = mcb_pkg::ST_CARVED;
                n_res.cell_x = r_nx[5:0];
                n_res.cell_y = r_ny[5:0];
                n_res.wall_x = r_wx;
                n_res.wall_y = r_wy;
            end
            mcb_pkg::S_EMIT: begin
                if (out_free) begin
                    n_ov  = 1'b1;
                    n_out = r_res;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (g_we) begin
            grid_mem[g_wa] <= g_wd;
        end
        if (g_re) begin
            r_g_q <= grid_mem[g_ra];
        end
        if (s_we) begin
            stk_mem[s_wa] <= s_wd;
        end
        if (s_re) begin
            r_s_q <= stk_mem[s_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mcb_pkg::S_CLEAR;
            r_clr     <= '0;
            r_clr_rep <= 1'b0;
            r_depth   <= '0;
            r_ov      <= 1'b0;
            r_width   <= 6'd31;
            r_height  <= 6'd31;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_clr_rep <= n_clr_rep;
            r_depth   <= n_depth;
            r_ov      <= n_ov;
            if (cfg_wr && paddr == mcb_pkg::REG_WIDTH) begin
                r_width <= pwdata[5:0];
            end
            if (cfg_wr && paddr == mcb_pkg::REG_HEIGHT) begin
                r_height <= pwdata[5:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_perm <= n_perm;
        r_nx   <= n_nx;
        r_ny   <= n_ny;
        r_wx   <= n_wx;
        r_wy   <= n_wy;
        r_inb  <= n_inb;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    always_comb begin
        pready = 1'b1;
        case (paddr)
            mcb_pkg::REG_WIDTH:  prdata = {26'd0, r_width};
            mcb_pkg::REG_HEIGHT: prdata = {26'd0, r_height};
            default:             prdata = '0;
        endcase
        o_out_valid = r_ov;
        o_status    = r_out.status;
        o_cell_x    = r_out.cell_x;
        o_cell_y    = r_out.cell_y;
        o_wall_x    = r_out.wall_x;
        o_wall_y    = r_out.wall_y;
        o_tile_open = r_out.tile_open;
    end

    // The stack never grows past its storage.
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_depth) <= STACK_DEPTH)
        else $error("stack depth beyond storage");

    // A push is only made from a successful check with room left on the stack.
    a_carve_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mcb_pkg::S_CARVE |-> int'(r_depth) < STACK_DEPTH
            && $past(r_state) == mcb_pkg::S_CHECK)
        else $error("carve without room or check");

    // The top entry is only decoded when the stack holds at least one cell.
    a_decode_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == mcb_pkg::S_DECODE |-> r_depth != '0)
        else $error("decode on empty stack");

endmodule
